// ----- rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  // Parser phases
  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] PH_PAY    = 3'd5;

  // Header fields
  localparam logic [3:0] OP_CLOSE       = 4'd8;
  localparam logic [3:0] OP_BINARY      = 4'd2;
  localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16      = 7'd126;

  // Result kinds
  localparam logic [2:0] K_DATA    = 3'd0;
  localparam logic [2:0] K_CLOSE   = 3'd1;
  localparam logic [2:0] K_IGNORED = 3'd2;
  localparam logic [2:0] K_NOMASK  = 3'd3;
  localparam logic [2:0] K_LONG    = 3'd4;
  localparam logic [2:0] K_EMPTY   = 3'd5;

  // Queue depth
  localparam int QDEPTH = 2;

  // One classified result waiting for the back end; the payload byte is
  // still masked, the mask byte travels with it.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
  } entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_status_t;

endpackage
`default_nettype wire

// ----- rtl/wsd_front.sv -----
// Front end: parser that takes and classifies one byte a cycle unless q_full.
`default_nettype none
module wsd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          q_full,
  output logic               push,
  output wsd_pkg::entry_t    push_entry
);

  logic [2:0]  phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_pos, mask_pos_next;
  logic        halted, halted_next;
  logic        accept;
  logic [7:0]  mask_byte;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (mask_pos)
      2'd0:    mask_byte = mask_key[31:24];
      2'd1:    mask_byte = mask_key[23:16];
      2'd2:    mask_byte = mask_key[15:8];
      default: mask_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    mask_key_next  = mask_key;
    mask_pos_next  = mask_pos;
    halted_next    = halted;
    push           = 1'b0;
    push_entry     = '{kind: wsd_pkg::K_DATA, data: 8'h00, mask: 8'h00, last: 1'b1};
    if (accept && !halted) begin
      case (phase)
        wsd_pkg::PH_LEN: begin
          if (!rx_byte[7]) begin
            phase_next      = wsd_pkg::PH_HDR;
            push            = 1'b1;
            push_entry.kind = wsd_pkg::K_NOMASK;
          end else if (rx_byte[6:0] <= wsd_pkg::LEN_DIRECT_MAX) begin
            remaining_next = {9'd0, rx_byte[6:0]};
            mask_pos_next  = 2'd0;
            phase_next     = wsd_pkg::PH_MASK;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_next = wsd_pkg::PH_EXT_HI;
          end else begin
            // 64-bit length: report once, then drop everything until reset
            halted_next     = 1'b1;
            phase_next      = wsd_pkg::PH_HDR;
            push            = 1'b1;
            push_entry.kind = wsd_pkg::K_LONG;
          end
        end
        wsd_pkg::PH_EXT_HI: begin
          remaining_next = {rx_byte, 8'h00};
          phase_next     = wsd_pkg::PH_EXT_LO;
        end
        wsd_pkg::PH_EXT_LO: begin
          remaining_next = {remaining[15:8], rx_byte};
          mask_pos_next  = 2'd0;
          phase_next     = wsd_pkg::PH_MASK;
        end
        wsd_pkg::PH_MASK: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          mask_pos_next = mask_pos + 2'd1;
          if (mask_pos == 2'd3) begin
            if (remaining == 16'd0) begin
              phase_next      = wsd_pkg::PH_HDR;
              push            = 1'b1;
              push_entry.kind = wsd_pkg::K_EMPTY;
            end else begin
              phase_next = wsd_pkg::PH_PAY;
            end
          end
        end
        wsd_pkg::PH_PAY: begin
          mask_pos_next   = mask_pos + 2'd1;
          remaining_next  = remaining - 16'd1;
          push            = 1'b1;
          push_entry.kind = wsd_pkg::K_DATA;
          push_entry.data = rx_byte;
          push_entry.mask = mask_byte;
          push_entry.last = (remaining == 16'd1);
          if (remaining == 16'd1) begin
            phase_next = wsd_pkg::PH_HDR;
          end
        end
        default: begin
          phase_next = wsd_pkg::PH_HDR;
          if (rx_byte[3:0] == wsd_pkg::OP_CLOSE) begin
            push            = 1'b1;
            push_entry.kind = wsd_pkg::K_CLOSE;
          end else if (rx_byte[3:0] != wsd_pkg::OP_BINARY) begin
            push            = 1'b1;
            push_entry.kind = wsd_pkg::K_IGNORED;
          end else begin
            phase_next = wsd_pkg::PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsd_pkg::PH_HDR;
      remaining <= 16'd0;
      mask_key  <= 32'd0;
      mask_pos  <= 2'd0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      mask_key  <= mask_key_next;
      mask_pos  <= mask_pos_next;
      halted    <= halted_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted cleared without reset");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst) halted |-> !push)
    else $error("result pushed while halted");
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == wsd_pkg::PH_PAY) |-> (remaining != 16'd0))
    else $error("payload phase with no bytes remaining");

endmodule
`default_nettype wire

// ----- rtl/wsd_queue.sv -----
// Two-entry queue between the parser and the output stage.
`default_nettype none
module wsd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire wsd_pkg::entry_t    push_entry,
  output logic                    full,
  input  wire logic               pop,
  output wsd_pkg::q_status_t      status
);

  wsd_pkg::entry_t mem [wsd_pkg::QDEPTH];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign full         = (count == 2'(wsd_pkg::QDEPTH));
  assign status.valid = (count != 2'd0);
  assign status.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wsd_back.sv -----
// Back end: unmask the payload byte and hold the result in the output register.
`default_nettype none
module wsd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wsd_pkg::q_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              kind,
  output logic [7:0]              data,
  output logic                    last
);

  // Refill the output register whenever it is empty or being taken
  assign pop = status.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= status.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= status.head.kind;
      data <= status.head.data ^ status.head.mask;
      last <= status.head.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket client frame deframer.
`default_nettype none
// Takes one received byte per word on the input channel and returns zero or
// one result word per byte: an unmasked payload byte (kind 0, last set on the
// final byte of the frame) or an event (close, ignored opcode, mask missing,
// unsupported 64-bit length, empty frame), each with last set and data zero.
// Only binary frames (opcode 2) are unmasked; 7-bit and 16-bit lengths are
// supported, a 64-bit length is reported once and then all input is dropped
// until reset. The FIN bit is not checked. Throughput is one byte per clock
// while the queue is not full: the header parser decides each byte
// combinationally, a two-entry queue lets it keep accepting while the output
// side is stalled, and each result passes through the queue and then the
// output register on its way out. in_ready drops only when the queue is full.
module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] rx_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [2:0]      kind,
  output logic [7:0]      data,
  output logic            last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic               q_full;
  logic               push;
  wsd_pkg::entry_t    push_entry;
  logic               pop;
  wsd_pkg::q_status_t q_status;

  // Parse headers and tag each payload byte with its mask byte
  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple parser from the output handshake
  wsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .status     (q_status)
  );

  // Unmask and present results
  wsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .status    (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data      (data),
    .last      (last)
  );

endmodule
`default_nettype wire
